// File: rtl/sam_pkg.sv
// Shared types and constants for the sensor alarm monitor.
// Used by the front, queue, back and checker modules; depends on nothing.
package sam_pkg;

    localparam int SAMPLE_W  = 12;
    localparam int KEY_W     = 5;
    localparam int CFG_W     = 16;
    localparam int CFG_IDX_W = 1;
    localparam int MUL_W     = 24;
    localparam int NUM_LANES = 4;

    localparam int ALARM_W   = 9;
    localparam int TEMP_T_W  = 12;
    localparam int LIMIT_T_W = 10;
    localparam int GAS_W     = 7;

    localparam logic [KEY_W-1:0] KEY_A    = 5'd4;
    localparam logic [KEY_W-1:0] KEY_B    = 5'd8;
    localparam logic [KEY_W-1:0] KEY_STAR = 5'd13;
    localparam logic [KEY_W-1:0] KEY_HASH = 5'd15;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_HOLDOFF = 1'b0,
        REG_PERIOD  = 1'b1
    } cfg_reg_t;

    localparam logic [CFG_W-1:0] HOLDOFF_RESET = 16'd300;
    localparam logic [CFG_W-1:0] PERIOD_RESET  = 16'd100;

    // Scaling lanes of the back end: each computes floor(sample * mul / full scale).
    localparam int LANE_TEMP_WHOLE  = 0;
    localparam int LANE_TEMP_TENTHS = 1;
    localparam int LANE_LIMIT       = 2;
    localparam int LANE_GAS         = 3;

    localparam logic [11:0] SCALE_MUL [NUM_LANES] = '{12'd330, 12'd3300, 12'd600, 12'd100};

    typedef struct packed {
        logic siren_on;
        logic watch_mode;
        logic mode_changed;
        logic dump_request;
        logic alarm_raised;
        logic alarm_dismissed;
        logic display_restore;
        logic status_report;
    } sam_flags_t;

    typedef struct packed {
        sam_flags_t          flags;
        logic [SAMPLE_W-1:0] pot;
        logic [SAMPLE_W-1:0] temp;
        logic [SAMPLE_W-1:0] gas;
    } sam_entry_t;

endpackage

// File: rtl/sensor_alarm_monitor.sv
// Top level of the sensor alarm monitor: front end, item queue and back end.
// Depends on sam_pkg, sam_front, sam_fifo and sam_back.
//
// The monitor takes one sensor tick per clock cycle and returns exactly one
// result item per tick, in order. The front end updates the alarm latch,
// watch mode, hold-off and status counters in the cycle an item is accepted
// and puts the classified item in a QUEUE_DEPTH-entry queue; that state update
// sets the sustained rate of one item per cycle. The back end scales the
// samples in a four-stage pipeline (multiply, two folds of the divide by full
// scale, correction into the result register). The input side stalls only
// when the queue is full. The user must make sure registers are written
// through the cfg port only while idle; the block does not enforce this.
module sensor_alarm_monitor #(
    parameter int ADC_BITS    = 12,
    parameter int QUEUE_DEPTH = 4
) (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            cfg_wr_en,
    input  logic [sam_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [sam_pkg::CFG_W-1:0]       cfg_wdata,
    input  logic                            s_valid,
    output logic                            s_ready,
    input  logic [sam_pkg::SAMPLE_W-1:0]    s_pot_raw,
    input  logic [sam_pkg::SAMPLE_W-1:0]    s_temp_raw,
    input  logic [sam_pkg::SAMPLE_W-1:0]    s_gas_raw,
    input  logic [sam_pkg::KEY_W-1:0]       s_key_code,
    output logic                            m_valid,
    input  logic                            m_ready,
    output logic                            m_siren_on,
    output logic                            m_watch_mode,
    output logic                            m_mode_changed,
    output logic                            m_dump_request,
    output logic                            m_alarm_raised,
    output logic                            m_alarm_dismissed,
    output logic                            m_display_restore,
    output logic                            m_status_report,
    output logic [sam_pkg::ALARM_W-1:0]     m_alarm_value,
    output logic [sam_pkg::TEMP_T_W-1:0]    m_temp_tenths,
    output logic [sam_pkg::LIMIT_T_W-1:0]   m_limit_tenths,
    output logic [sam_pkg::GAS_W-1:0]       m_gas_index
);
    import sam_pkg::*;

    sam_entry_t front_entry, queue_head;
    logic       accept, queue_full, queue_not_empty, back_ready, pop;

    assign s_ready = !queue_full;
    assign accept  = s_valid && s_ready;
    assign pop     = queue_not_empty && back_ready;

    sam_front #(
        .ADC_BITS (ADC_BITS)
    ) u_front (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .pot_raw   (s_pot_raw),
        .temp_raw  (s_temp_raw),
        .gas_raw   (s_gas_raw),
        .key_code  (s_key_code),
        .accept    (accept),
        .entry     (front_entry)
    );

    sam_fifo #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push       (accept),
        .push_entry (front_entry),
        .full       (queue_full),
        .pop        (pop),
        .not_empty  (queue_not_empty),
        .head       (queue_head)
    );

    sam_back #(
        .ADC_BITS (ADC_BITS)
    ) u_back (
        .aclk              (aclk),
        .aresetn           (aresetn),
        .in_valid          (queue_not_empty),
        .in_ready          (back_ready),
        .entry             (queue_head),
        .m_valid           (m_valid),
        .m_ready           (m_ready),
        .m_siren_on        (m_siren_on),
        .m_watch_mode      (m_watch_mode),
        .m_mode_changed    (m_mode_changed),
        .m_dump_request    (m_dump_request),
        .m_alarm_raised    (m_alarm_raised),
        .m_alarm_dismissed (m_alarm_dismissed),
        .m_display_restore (m_display_restore),
        .m_status_report   (m_status_report),
        .m_alarm_value     (m_alarm_value),
        .m_temp_tenths     (m_temp_tenths),
        .m_limit_tenths    (m_limit_tenths),
        .m_gas_index       (m_gas_index)
    );

endmodule

// File: rtl/sam_front.sv
// Front end: configuration registers, alarm state and per-item classification.
// Depends on sam_pkg.
module sam_front #(
    parameter int ADC_BITS = 12
) (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           cfg_wr_en,
    input  logic [sam_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [sam_pkg::CFG_W-1:0]      cfg_wdata,
    input  logic [sam_pkg::SAMPLE_W-1:0]   pot_raw,
    input  logic [sam_pkg::SAMPLE_W-1:0]   temp_raw,
    input  logic [sam_pkg::SAMPLE_W-1:0]   gas_raw,
    input  logic [sam_pkg::KEY_W-1:0]      key_code,
    input  logic                           accept,
    output sam_pkg::sam_entry_t            entry
);
    import sam_pkg::*;

    localparam int FS_W = 17;
    localparam logic [FS_W-1:0] FULL_SCALE = FS_W'((1 << ADC_BITS) - 1);
    localparam int FLT_W = SAMPLE_W + 4;

    logic [CFG_W-1:0] holdoff_ticks_reg;
    logic [CFG_W-1:0] status_period_reg;
    logic             mode_gas_reg, mode_gas_next;
    logic             siren_reg, siren_next;
    logic [CFG_W-1:0] holdoff_reg, holdoff_next;
    logic [CFG_W-1:0] status_reg, status_next;

    logic [SAMPLE_W-1:0] pot_s, temp_s, gas_s;
    logic [FLT_W-1:0]    temp_x11, pot_x2, gas_x10, pot_x9;
    logic [CFG_W-1:0]    holdoff_dec, status_inc;
    logic                fault, raise, siren_mid;
    sam_flags_t          flags;

    function automatic logic [SAMPLE_W-1:0] saturate(input logic [SAMPLE_W-1:0] raw);
        saturate = (FS_W'(raw) > FULL_SCALE) ? FULL_SCALE[SAMPLE_W-1:0] : raw;
    endfunction

    assign pot_s  = saturate(pot_raw);
    assign temp_s = saturate(temp_raw);
    assign gas_s  = saturate(gas_raw);

    assign temp_x11 = FLT_W'(temp_s) * FLT_W'(11);
    assign pot_x2   = FLT_W'(pot_s) * FLT_W'(2);
    assign gas_x10  = FLT_W'(gas_s) * FLT_W'(10);
    assign pot_x9   = FLT_W'(pot_s) * FLT_W'(9);

    always_comb begin
        flags         = '0;
        holdoff_dec   = holdoff_reg;
        mode_gas_next = mode_gas_reg;
        status_inc    = status_reg + CFG_W'(1);
        status_next   = status_reg;

        // Hold-off counts down before anything else in the tick.
        if (holdoff_reg != '0) begin
            holdoff_dec = holdoff_reg - CFG_W'(1);
            flags.display_restore = (holdoff_dec == '0) && !siren_reg;
        end
        holdoff_next = holdoff_dec;

        if ((key_code == KEY_A || key_code == KEY_B) && !siren_reg) begin
            mode_gas_next      = (key_code == KEY_B);
            flags.mode_changed = 1'b1;
        end
        flags.dump_request = (key_code == KEY_STAR) && !siren_reg;

        fault     = mode_gas_next ? (gas_x10 > pot_x9) : (temp_x11 > pot_x2);
        raise     = fault && !siren_reg && (holdoff_dec == '0);
        siren_mid = siren_reg || raise;
        flags.alarm_raised = raise;
        siren_next = siren_mid;

        if (siren_mid) begin
            if (key_code == KEY_HASH) begin
                siren_next            = 1'b0;
                flags.alarm_dismissed = 1'b1;
                holdoff_next          = holdoff_ticks_reg;
            end
        end else begin
            status_next = status_inc;
            if (status_inc >= status_period_reg) begin
                flags.status_report = 1'b1;
                status_next         = '0;
            end
        end

        flags.siren_on   = siren_next;
        flags.watch_mode = mode_gas_next;
    end

    assign entry.flags = flags;
    assign entry.pot   = pot_s;
    assign entry.temp  = temp_s;
    assign entry.gas   = gas_s;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            holdoff_ticks_reg <= HOLDOFF_RESET;
            status_period_reg <= PERIOD_RESET;
        end else if (cfg_wr_en) begin
            case (cfg_reg_t'(cfg_index))
                REG_HOLDOFF: holdoff_ticks_reg <= cfg_wdata;
                REG_PERIOD:  status_period_reg <= cfg_wdata;
                default: ;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mode_gas_reg <= 1'b0;
            siren_reg    <= 1'b0;
            holdoff_reg  <= '0;
            status_reg   <= '0;
        end else if (accept) begin
            mode_gas_reg <= mode_gas_next;
            siren_reg    <= siren_next;
            holdoff_reg  <= holdoff_next;
            status_reg   <= status_next;
        end
    end

endmodule

// File: rtl/sam_fifo.sv
// Short item queue between the front and back ends.
// Depends on sam_pkg for the entry type.
module sam_fifo #(
    parameter int DEPTH = 4
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                push,
    input  sam_pkg::sam_entry_t push_entry,
    output logic                full,
    input  logic                pop,
    output logic                not_empty,
    output sam_pkg::sam_entry_t head
);
    import sam_pkg::*;

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    sam_entry_t         store_reg [DEPTH];
    logic [PTR_W-1:0]   wr_ptr_reg, rd_ptr_reg;
    logic [CNT_W-1:0]   count_reg, count_next;

    function automatic logic [PTR_W-1:0] bump(input logic [PTR_W-1:0] ptr);
        bump = (ptr == PTR_W'(DEPTH - 1)) ? '0 : ptr + PTR_W'(1);
    endfunction

    assign full      = (count_reg == CNT_W'(DEPTH));
    assign not_empty = (count_reg != '0);
    assign head      = store_reg[rd_ptr_reg];

    always_comb begin
        count_next = count_reg;
        if (push && !pop) begin
            count_next = count_reg + CNT_W'(1);
        end else if (pop && !push) begin
            count_next = count_reg - CNT_W'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            count_reg <= count_next;
            if (push) begin
                wr_ptr_reg <= bump(wr_ptr_reg);
            end
            if (pop) begin
                rd_ptr_reg <= bump(rd_ptr_reg);
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            store_reg[wr_ptr_reg] <= push_entry;
        end
    end

endmodule

// File: rtl/sam_back.sv
// Back end: scales samples to display units and drives the result register.
// Depends on sam_pkg.
module sam_back #(
    parameter int ADC_BITS = 12
) (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            in_valid,
    output logic                            in_ready,
    input  sam_pkg::sam_entry_t             entry,
    output logic                            m_valid,
    input  logic                            m_ready,
    output logic                            m_siren_on,
    output logic                            m_watch_mode,
    output logic                            m_mode_changed,
    output logic                            m_dump_request,
    output logic                            m_alarm_raised,
    output logic                            m_alarm_dismissed,
    output logic                            m_display_restore,
    output logic                            m_status_report,
    output logic [sam_pkg::ALARM_W-1:0]     m_alarm_value,
    output logic [sam_pkg::TEMP_T_W-1:0]    m_temp_tenths,
    output logic [sam_pkg::LIMIT_T_W-1:0]   m_limit_tenths,
    output logic [sam_pkg::GAS_W-1:0]       m_gas_index
);
    import sam_pkg::*;

    localparam logic [MUL_W-1:0] FULL_SCALE = MUL_W'((1 << ADC_BITS) - 1);

    // Division by 2^N-1 is done by folding: x = q*2^N + l gives x = q*d + (q + l).
    // Two folds leave a remainder below twice the full scale, so one
    // compare-and-subtract finishes it.
    logic [SAMPLE_W-1:0] lane_in [NUM_LANES];
    logic [MUL_W-1:0]    s1_x_reg [NUM_LANES];
    logic [MUL_W-1:0]    s2_q_reg [NUM_LANES];
    logic [MUL_W-1:0]    s2_r_reg [NUM_LANES];
    logic [MUL_W-1:0]    s3_q_reg [NUM_LANES];
    logic [MUL_W-1:0]    s3_r_reg [NUM_LANES];
    logic [MUL_W-1:0]    quot [NUM_LANES];

    sam_flags_t s1_flags_reg, s2_flags_reg, s3_flags_reg;
    logic       s1_valid_reg, s2_valid_reg, s3_valid_reg, m_valid_reg;
    logic       out_free, s3_free, s2_free, s1_free;

    assign out_free = !m_valid_reg || m_ready;
    assign s3_free  = !s3_valid_reg || out_free;
    assign s2_free  = !s2_valid_reg || s3_free;
    assign s1_free  = !s1_valid_reg || s2_free;
    assign in_ready = s1_free;
    assign m_valid  = m_valid_reg;

    assign lane_in[LANE_TEMP_WHOLE]  = entry.temp;
    assign lane_in[LANE_TEMP_TENTHS] = entry.temp;
    assign lane_in[LANE_LIMIT]       = entry.pot;
    assign lane_in[LANE_GAS]         = entry.gas;

    for (genvar i = 0; i < NUM_LANES; i++) begin : g_lane
        always_ff @(posedge aclk) begin
            if (in_valid && s1_free) begin
                s1_x_reg[i] <= MUL_W'(lane_in[i]) * MUL_W'(SCALE_MUL[i]);
            end
            if (s1_valid_reg && s2_free) begin
                s2_q_reg[i] <= s1_x_reg[i] >> ADC_BITS;
                s2_r_reg[i] <= (s1_x_reg[i] >> ADC_BITS) + MUL_W'(s1_x_reg[i][ADC_BITS-1:0]);
            end
            if (s2_valid_reg && s3_free) begin
                s3_q_reg[i] <= s2_q_reg[i] + (s2_r_reg[i] >> ADC_BITS);
                s3_r_reg[i] <= (s2_r_reg[i] >> ADC_BITS) + MUL_W'(s2_r_reg[i][ADC_BITS-1:0]);
            end
        end
        assign quot[i] = s3_q_reg[i] + MUL_W'(s3_r_reg[i] >= FULL_SCALE);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
            s3_valid_reg <= 1'b0;
            m_valid_reg  <= 1'b0;
        end else begin
            if (s1_free) begin
                s1_valid_reg <= in_valid;
            end
            if (s2_free) begin
                s2_valid_reg <= s1_valid_reg;
            end
            if (s3_free) begin
                s3_valid_reg <= s2_valid_reg;
            end
            if (out_free) begin
                m_valid_reg <= s3_valid_reg;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (in_valid && s1_free) begin
            s1_flags_reg <= entry.flags;
        end
        if (s1_valid_reg && s2_free) begin
            s2_flags_reg <= s1_flags_reg;
        end
        if (s2_valid_reg && s3_free) begin
            s3_flags_reg <= s2_flags_reg;
        end
        if (s3_valid_reg && out_free) begin
            m_siren_on        <= s3_flags_reg.siren_on;
            m_watch_mode      <= s3_flags_reg.watch_mode;
            m_mode_changed    <= s3_flags_reg.mode_changed;
            m_dump_request    <= s3_flags_reg.dump_request;
            m_alarm_raised    <= s3_flags_reg.alarm_raised;
            m_alarm_dismissed <= s3_flags_reg.alarm_dismissed;
            m_display_restore <= s3_flags_reg.display_restore;
            m_status_report   <= s3_flags_reg.status_report;
            if (!s3_flags_reg.alarm_raised) begin
                m_alarm_value <= '0;
            end else if (s3_flags_reg.watch_mode) begin
                m_alarm_value <= ALARM_W'(quot[LANE_GAS]);
            end else begin
                m_alarm_value <= ALARM_W'(quot[LANE_TEMP_WHOLE]);
            end
            if (s3_flags_reg.status_report) begin
                m_temp_tenths  <= TEMP_T_W'(quot[LANE_TEMP_TENTHS]);
                m_limit_tenths <= LIMIT_T_W'(quot[LANE_LIMIT]);
                m_gas_index    <= GAS_W'(quot[LANE_GAS]);
            end else begin
                m_temp_tenths  <= '0;
                m_limit_tenths <= '0;
                m_gas_index    <= '0;
            end
        end
    end

endmodule

// File: rtl/sam_checker.sv
// Port-level checks on the result channel of the sensor alarm monitor.
// Depends on sam_pkg; bound to sensor_alarm_monitor at the end of this file.
module sam_checker (
    input logic                            aclk,
    input logic                            aresetn,
    input logic                            m_valid,
    input logic                            m_ready,
    input logic                            m_siren_on,
    input logic                            m_alarm_raised,
    input logic                            m_alarm_dismissed,
    input logic                            m_status_report,
    input logic [sam_pkg::ALARM_W-1:0]     m_alarm_value,
    input logic [sam_pkg::TEMP_T_W-1:0]    m_temp_tenths,
    input logic [sam_pkg::LIMIT_T_W-1:0]   m_limit_tenths,
    input logic [sam_pkg::GAS_W-1:0]       m_gas_index
);

    a_reset_empty: assert property (@(posedge aclk) !aresetn |=> !m_valid)
        else $error("result valid right after reset");

    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_alarm_value)
            && $stable(m_temp_tenths) && $stable(m_siren_on))
        else $error("stalled result item changed");

    // A raised alarm leaves the siren on unless the same tick dismissed it.
    a_raise_latches: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_alarm_raised |-> m_siren_on || m_alarm_dismissed)
        else $error("alarm raised but siren off");

    // Status reports come only from idle ticks, and carry data only then.
    a_report_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_status_report |-> !m_siren_on)
        else $error("status report with siren on");

    a_fields_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_status_report |-> m_temp_tenths == '0 && m_limit_tenths == '0
            && m_gas_index == '0 && (m_alarm_raised || m_alarm_value == '0))
        else $error("status or alarm fields nonzero without their flag");

endmodule

bind sensor_alarm_monitor sam_checker u_sam_checker (.*);
